@@ design/pft_pkg.sv @@
// Package for the prefix forwarding table: beat types, codes and defaults.
// No dependencies.
`timescale 1ns / 1ps
package pft_pkg;
    localparam int DEFAULT_ENTRIES = 64;

    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_ADD    = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] address;
        logic [31:0] mask;
    } pft_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  slot;
        logic [31:0] matched_prefix;
        logic [31:0] matched_mask;
        logic [6:0]  entry_count;
    } pft_rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request
        logic scan;     // register per-cell match results
        logic commit;   // shift cells for add/remove, update count
    } pft_cmd_t;
endpackage

@@ design/pft_datapath.sv @@
// Cell chain holding the route table, with per-cell compare and priority pick.
// Depends on pft_pkg.
`timescale 1ns / 1ps
module pft_datapath
    import pft_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  pft_req_t req,
    input  pft_cmd_t cmd,
    output pft_rsp_t rsp
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic [31:0]   prefix_reg [ENTRIES];
    logic [31:0]   mask_reg   [ENTRIES];
    logic [CW-1:0] count_reg, count_next;
    pft_req_t      req_reg;

    logic [ENTRIES-1:0] valid;
    logic [ENTRIES-1:0] lk_hit, rm_hit, ge_hit;
    logic [ENTRIES-1:0] lk_hit_reg, rm_hit_reg, ge_hit_reg;

    // per-cell compares, registered before the priority pick
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            valid[i]  = (CW'(i) < count_reg);
            lk_hit[i] = valid[i] && ((mask_reg[i] & req_reg.address) == prefix_reg[i]);
            rm_hit[i] = valid[i] && (prefix_reg[i] == req_reg.address)
                        && (mask_reg[i] == req_reg.mask);
            ge_hit[i] = valid[i] && (mask_reg[i] >= req_reg.mask);
        end
    end

    logic          lk_any, rm_any;
    logic [IW-1:0] lk_pos, rm_pos;
    logic [CW-1:0] add_pos;
    logic          full;

    always_comb
    begin
        lk_any  = 1'b0;
        rm_any  = 1'b0;
        lk_pos  = '0;
        rm_pos  = '0;
        add_pos = CW'(ENTRIES);
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (lk_hit_reg[i])
            begin
                lk_any = 1'b1;
                lk_pos = IW'(i);
            end
            if (rm_hit_reg[i])
            begin
                rm_any = 1'b1;
                rm_pos = IW'(i);
            end
            // masks are sorted descending, so the >= cells form a leading run
            if (!ge_hit_reg[i])
                add_pos = CW'(i);
        end
        full = (count_reg == CW'(ENTRIES));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.commit)
        begin
            unique case (req_reg.func)
                FUNC_ADD:    if (!full) count_next = count_reg + CW'(1);
                FUNC_REMOVE: if (rm_any) count_next = count_reg - CW'(1);
                default:     count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
        if (cmd.scan)
        begin
            lk_hit_reg <= lk_hit;
            rm_hit_reg <= rm_hit;
            ge_hit_reg <= ge_hit;
        end
        if (cmd.commit && req_reg.func == FUNC_ADD && !full)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (CW'(i) == add_pos)
                begin
                    prefix_reg[i] <= req_reg.address;
                    mask_reg[i]   <= req_reg.mask;
                end
                else if (CW'(i) > add_pos && i > 0)
                begin
                    prefix_reg[i] <= prefix_reg[(i > 0) ? i - 1 : 0];
                    mask_reg[i]   <= mask_reg[(i > 0) ? i - 1 : 0];
                end
            end
        end
        if (cmd.commit && req_reg.func == FUNC_REMOVE && rm_any)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (CW'(i) + CW'(1) == count_reg)
                begin
                    prefix_reg[i] <= '0;
                    mask_reg[i]   <= '0;
                end
                else if (IW'(i) >= rm_pos && i < ENTRIES - 1)
                begin
                    prefix_reg[i] <= prefix_reg[(i < ENTRIES - 1) ? i + 1 : i];
                    mask_reg[i]   <= mask_reg[(i < ENTRIES - 1) ? i + 1 : i];
                end
            end
        end
    end

    // result from commit-cycle values; count is the post-operation value
    always_comb
    begin
        rsp             = '0;
        rsp.status      = STATUS_MISS;
        rsp.entry_count = 7'(count_next);
        unique case (req_reg.func)
            FUNC_LOOKUP:
                if (lk_any)
                begin
                    rsp.status         = STATUS_OK;
                    rsp.slot           = 6'(lk_pos);
                    rsp.matched_prefix = prefix_reg[lk_pos];
                    rsp.matched_mask   = mask_reg[lk_pos];
                end
            FUNC_ADD:
                if (full)
                    rsp.status = STATUS_FULL;
                else
                begin
                    rsp.status = STATUS_OK;
                    rsp.slot   = 6'(add_pos);
                end
            FUNC_REMOVE:
                if (rm_any)
                begin
                    rsp.status = STATUS_OK;
                    rsp.slot   = 6'(rm_pos);
                end
            default:
                rsp.status = STATUS_MISS;
        endcase
    end
endmodule

@@ design/pft_ctrl.sv @@
// Controller: sequences load, scan and commit for one operation.
// Depends on pft_pkg.
`timescale 1ns / 1ps
module pft_ctrl
    import pft_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output logic     done,
    output pft_cmd_t cmd
);
    typedef enum logic [1:0] {IDLE, SCAN, COMMIT} state_t;
    state_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= IDLE;
        else
        begin
            unique case (state_reg)
                IDLE:    if (start) state_reg <= SCAN;
                SCAN:    state_reg <= COMMIT;
                COMMIT:  state_reg <= IDLE;
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign busy       = (state_reg != IDLE);
    assign done       = (state_reg == COMMIT);
    assign cmd.load   = (state_reg == IDLE) && start;
    assign cmd.scan   = (state_reg == SCAN);
    assign cmd.commit = (state_reg == COMMIT);
endmodule

@@ design/prefix_forwarding_table_top.sv @@
// Prefix forwarding table, top level.
// Start beat, then the scan state, then the commit state with the result strobe; no new operation is taken while busy.
// Cycles: capture, registered per-cell compare, priority pick and table shift.
// Reset clears the entry count; table contents are undefined until written.
// The receiver cannot stall: the result is shown for one cycle on done.
`timescale 1ns / 1ps
module prefix_forwarding_table_top
    import pft_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  pft_req_t req,
    output logic     done,
    output pft_rsp_t rsp
);
    pft_cmd_t cmd;
    pft_rsp_t rsp_comb;

    pft_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start),
        .busy(busy), .done(done), .cmd(cmd)
    );

    pft_datapath #(.ENTRIES(ENTRIES)) u_dp (
        .clk(clk), .rst_n(rst_n), .req(req), .cmd(cmd), .rsp(rsp_comb)
    );

    assign rsp = done ? rsp_comb : '0;
endmodule

@@ design/pft_checker.sv @@
// Port-level checker for the prefix forwarding table, bound to the top level.
// Depends on pft_pkg.
`timescale 1ns / 1ps
module pft_checker
    import pft_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input pft_rsp_t rsp
);
    a_done_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("no result two cycles after start");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result while idle");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held");

    a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != STATUS_OK) |-> (rsp.slot == '0))
        else $error("slot nonzero on failure");
endmodule

bind prefix_forwarding_table_top pft_checker u_pft_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);

@@ sim/tb.sv @@
// Testbench for prefix_forwarding_table_top: directed and random route
// add/remove/lookup beats checked against an in-bench route table predictor.
// Depends on pft_pkg and prefix_forwarding_table_top.
`timescale 1ns / 1ps
module tb;
    import pft_pkg::*;

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 400000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    pft_req_t req;
    logic     done;
    pft_rsp_t rsp;

    logic [31:0] route_prefix [DEPTH];
    logic [31:0] route_mask [DEPTH];
    int          route_count;
    pft_rsp_t    pending_rsp [$];
    int          error_count = 0;
    int          cycle_count = 0;

    prefix_forwarding_table_top #(.ENTRIES(DEPTH)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Predict the response of one beat and update the route table.
    function automatic pft_rsp_t route_table_op(pft_req_t r);
        pft_rsp_t o;
        int       pos;
        o = '0;
        o.status = STATUS_MISS;
        if (r.func == FUNC_LOOKUP)
        begin
            for (int i = 0; i < route_count; i++)
            begin
                if ((route_mask[i] & r.address) == route_prefix[i])
                begin
                    o.status = STATUS_OK;
                    o.slot = i[5:0];
                    o.matched_prefix = route_prefix[i];
                    o.matched_mask = route_mask[i];
                    break;
                end
            end
        end
        else if (r.func == FUNC_ADD)
        begin
            if (route_count >= DEPTH)
                o.status = STATUS_FULL;
            else
            begin
                pos = 0;
                while (pos < route_count && route_mask[pos] >= r.mask)
                    pos++;
                for (int i = route_count; i > pos; i--)
                begin
                    route_prefix[i] = route_prefix[i-1];
                    route_mask[i] = route_mask[i-1];
                end
                route_prefix[pos] = r.address;
                route_mask[pos] = r.mask;
                route_count++;
                o.status = STATUS_OK;
                o.slot = pos[5:0];
            end
        end
        else if (r.func == FUNC_REMOVE)
        begin
            pos = -1;
            for (int i = 0; i < route_count; i++)
            begin
                if (route_prefix[i] == r.address && route_mask[i] == r.mask)
                begin
                    pos = i;
                    break;
                end
            end
            if (pos >= 0)
            begin
                for (int i = pos; i + 1 < route_count; i++)
                begin
                    route_prefix[i] = route_prefix[i+1];
                    route_mask[i] = route_mask[i+1];
                end
                route_count--;
                route_prefix[route_count] = '0;
                route_mask[route_count] = '0;
                o.status = STATUS_OK;
                o.slot = pos[5:0];
            end
        end
        o.entry_count = route_count[6:0];
        return o;
    endfunction

    always @(posedge clk)
    begin
        pft_rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("unexpected result beat");
                error_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status exp %0d got %0d", want.status, rsp.status);
                    error_count++;
                end
                if (rsp.slot !== want.slot)
                begin
                    $error("slot exp %0d got %0d", want.slot, rsp.slot);
                    error_count++;
                end
                if (rsp.matched_prefix !== want.matched_prefix)
                begin
                    $error("matched_prefix exp %h got %h", want.matched_prefix,
                           rsp.matched_prefix);
                    error_count++;
                end
                if (rsp.matched_mask !== want.matched_mask)
                begin
                    $error("matched_mask exp %h got %h", want.matched_mask,
                           rsp.matched_mask);
                    error_count++;
                end
                if (rsp.entry_count !== want.entry_count)
                begin
                    $error("entry_count exp %0d got %0d", want.entry_count,
                           rsp.entry_count);
                    error_count++;
                end
            end
        end
    end

    // Mostly short gaps, occasionally long, sometimes none.
    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 40)
            return;
        else if (n < 95)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(4, 30);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Drive one beat; held until accepted at an edge with busy low.
    // start stays high after the accepting edge until the next gap or the end.
    task automatic send_beat(logic [1:0] f, logic [31:0] a, logic [31:0] m);
        pft_req_t r;
        idle_gap();
        r.func = f;
        r.address = a;
        r.mask = m;
        start <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (busy);
        pending_rsp.push_back(route_table_op(r));
    endtask

    function automatic logic [31:0] prefix_mask(int len);
        return (len == 0) ? 32'h0 : (32'hffffffff << (32 - len));
    endfunction

    task automatic test_directed();
        send_beat(FUNC_LOOKUP, 32'hffffffff, 32'h0);       // empty table miss
        send_beat(FUNC_REMOVE, 32'h0, 32'h0);              // remove from empty
        send_beat(FUNC_ADD, 32'h0a000000, 32'hff000000);
        send_beat(FUNC_ADD, 32'h0a010000, 32'hffff0000);
        send_beat(FUNC_ADD, 32'h0, 32'h0);                 // default route
        send_beat(FUNC_ADD, 32'hffffffff, 32'hffffffff);
        send_beat(FUNC_ADD, 32'h0a000000, 32'hff000000);   // duplicate
        send_beat(FUNC_LOOKUP, 32'h0a010203, 32'h0);
        send_beat(FUNC_LOOKUP, 32'h0a020304, 32'hffffffff);
        send_beat(FUNC_LOOKUP, 32'hffffffff, 32'h0);
        send_beat(FUNC_LOOKUP, 32'h55555555, 32'h0);
        send_beat(FUNC_NONE, 32'hffffffff, 32'hffffffff);  // unused code
        send_beat(FUNC_REMOVE, 32'h0a000000, 32'hff000000);
        send_beat(FUNC_REMOVE, 32'h12345678, 32'hff000000);
        send_beat(FUNC_LOOKUP, 32'h0a7f0000, 32'h0);
        send_beat(FUNC_ADD, 32'h12345678, 32'h0f0f0f0f);   // ill-formed mask
        send_beat(FUNC_LOOKUP, 32'h12345678, 32'h0);
    endtask

    task automatic test_full_table();
        while (route_count < DEPTH)
            send_beat(FUNC_ADD, $urandom(), prefix_mask($urandom_range(0, 32)));
        send_beat(FUNC_ADD, 32'h01020304, 32'hffffffff);   // full
        send_beat(FUNC_LOOKUP, $urandom(), 32'h0);
        send_beat(FUNC_REMOVE, route_prefix[DEPTH-1], route_mask[DEPTH-1]);
        send_beat(FUNC_ADD, 32'h01020304, 32'hffffffff);
        while (route_count > 0)
            send_beat(FUNC_REMOVE, route_prefix[0], route_mask[0]);
    endtask

    task automatic test_random(int beats);
        int          k;
        int          len;
        logic [31:0] m;
        logic [31:0] a;
        for (int n = 0; n < beats; n++)
        begin
            k = $urandom_range(0, 99);
            len = $urandom_range(0, 32);
            m = ($urandom_range(0, 9) == 0) ? $urandom() : prefix_mask(len);
            if (k < 35 && route_count < DEPTH - 2)
                send_beat(FUNC_ADD, $urandom() & m, m);
            else if (k < 55 && route_count > 0)
            begin
                int i;
                i = $urandom_range(0, route_count - 1);
                send_beat(FUNC_REMOVE, route_prefix[i], route_mask[i]);
            end
            else if (k < 60)
                send_beat(FUNC_REMOVE, $urandom(), m);
            else if (k < 62)
                send_beat(FUNC_NONE, $urandom(), $urandom());
            else
            begin
                // bias lookups towards stored routes so most hit
                a = $urandom();
                if (route_count > 0 && $urandom_range(0, 3) != 0)
                begin
                    int i;
                    i = $urandom_range(0, route_count - 1);
                    a = route_prefix[i] | (a & ~route_mask[i]);
                end
                send_beat(FUNC_LOOKUP, a, $urandom());
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        route_count = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            route_prefix[i] = '0;
            route_mask[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_table();
        test_random(1800);
        start <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

@@ files.f @@
design/pft_pkg.sv
design/pft_datapath.sv
design/pft_ctrl.sv
design/prefix_forwarding_table_top.sv
design/pft_checker.sv
sim/tb.sv
